FILE: hw/rtl/rwalu_pkg.sv
`timescale 1ns / 1ps
// shared types and codes of the range wrapped integer alu
package rwalu_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned REG_IDX_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_PREINC  = 3'd3,
    OP_POSTINC = 3'd4,
    OP_MUL     = 3'd5,
    OP_DIV     = 3'd6,
    OP_NEG     = 3'd7
  } rwalu_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_NDIV  = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_EMPTY = 2'd3
  } rwalu_status_e;

  localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  typedef struct packed {
    logic start;
    logic long_run;
  } rwalu_div_ctrl_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rwalu_div_stat_t;

endpackage

FILE: hw/rtl/rwalu_divider.sv
`timescale 1ns / 1ps
// shared restoring shift-subtract divider, one quotient bit per cycle
module rwalu_divider #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rwalu_pkg::rwalu_div_ctrl_t   ctrl_i,
  input  logic [2*VALUE_WIDTH-1:0]     dividend_i,
  input  logic [VALUE_WIDTH:0]         divisor_i,
  output rwalu_pkg::rwalu_div_stat_t   stat_o,
  output logic [2*VALUE_WIDTH-1:0]     quotient_o,
  output logic [VALUE_WIDTH:0]         remainder_o
);
  import rwalu_pkg::*;

  localparam int unsigned DW = 2 * VALUE_WIDTH;
  localparam int unsigned RW = VALUE_WIDTH + 1;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q, dvd_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic          fits;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      rem_d = '0;
      cnt_d = ctrl_i.long_run ? CW'(DW) : CW'(VALUE_WIDTH);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[RW-1:0] : trial[RW-1:0];
      dvd_d  = {dvd_q[DW-2:0], fits};
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);
  assign quotient_o      = dvd_q;
  assign remainder_o     = rem_q;

endmodule

FILE: hw/rtl/range_wrapped_integer_alu_core.sv
`timescale 1ns / 1ps
// range wrapped integer alu: accumulator kept in a configured circular range
//
//   channel   direction  tdata            tuser
//   s_axis    in         operand          req_type
//   m_axis    out        result_value     status
//   cfg       in         write only, index 0 range_low, 1 range_high
//
// the shared divider runs VALUE_WIDTH steps for an exact divide,
// then 2*VALUE_WIDTH steps for the range reduction of every ok result
// range empty, divide by zero and an inexact divide skip the reduction
// reset: accumulator 1, range 1..12
// a finished result waits in the output register; the next item is taken meanwhile
module range_wrapped_integer_alu_core #(
  parameter  int unsigned VALUE_WIDTH = 16,
  localparam int unsigned TDW         = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rwalu_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]           cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [TDW-1:0]                   s_axis_tdata,  // operand
  input  logic [rwalu_pkg::OP_W-1:0]       s_axis_tuser,  // req_type
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [TDW-1:0]                   m_axis_tdata,  // result_value
  output logic [rwalu_pkg::ST_W-1:0]       m_axis_tuser   // status
);
  import rwalu_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned DW = 2 * W;
  localparam int unsigned XW = 2 * W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DCHK = 3'd2;
  localparam logic [2:0] S_SUBL = 3'd3;
  localparam logic [2:0] S_MSET = 3'd4;
  localparam logic [2:0] S_MOD  = 3'd5;
  localparam logic [2:0] S_FIX  = 3'd6;
  localparam logic [2:0] S_WB   = 3'd7;

  logic [2:0]            state_q, state_d;
  logic signed [W-1:0]   acc_q, acc_d;
  logic signed [W-1:0]   low_q, high_q;
  rwalu_op_e             op_q, op_d;
  rwalu_status_e         status_q, status_d;
  logic signed [XW-1:0]  x_q, x_d;
  logic                  qneg_q, qneg_d;
  logic                  tneg_q, tneg_d;
  logic signed [W-1:0]   wrap_q, wrap_d;
  logic                  out_valid_q, out_valid_d;
  logic [W-1:0]          out_data_q, out_data_d;
  rwalu_status_e         out_status_q, out_status_d;

  rwalu_op_e             in_op;
  logic signed [W-1:0]   in_b;
  logic [W-1:0]          acc_abs, b_abs;
  logic signed [DW-1:0]  prod;
  logic signed [XW-1:0]  x_new;
  logic signed [XW-1:0]  x_abs;
  logic signed [XW-1:0]  q_ext;
  logic [W+1:0]          span_full;
  logic [W:0]            span;
  logic                  range_empty;
  logic [W:0]            r_adj;
  logic [W+1:0]          wrap_sum;
  logic                  out_free;

  rwalu_div_ctrl_t       div_ctrl;
  rwalu_div_stat_t       div_stat;
  logic [DW-1:0]         div_dividend;
  logic [W:0]            div_divisor;
  logic [DW-1:0]         div_quot;
  logic [W:0]            div_rem;

  rwalu_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign in_op       = rwalu_op_e'(s_axis_tuser);
  assign in_b        = s_axis_tdata[W-1:0];
  assign acc_abs     = acc_q[W-1] ? W'(-acc_q) : acc_q;
  assign b_abs       = in_b[W-1] ? W'(-in_b) : in_b;
  assign prod        = acc_q * in_b;
  assign span_full   = (W+2)'(high_q) - (W+2)'(low_q) + (W+2)'(1);
  assign span        = span_full[W:0];
  assign range_empty = (high_q < low_q);
  assign x_abs       = x_q[XW-1] ? -x_q : x_q;
  assign q_ext       = XW'(div_quot[W-1:0]);
  assign r_adj       = (tneg_q && !div_stat.rem_zero) ? (span - div_rem) : div_rem;
  assign wrap_sum    = {1'b0, r_adj} + (W+2)'(low_q);
  assign out_free    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    unique case (in_op)
      OP_LOAD:    x_new = XW'(in_b);
      OP_ADD:     x_new = XW'(acc_q) + XW'(in_b);
      OP_SUB:     x_new = XW'(acc_q) - XW'(in_b);
      OP_PREINC:  x_new = XW'(acc_q) + XW'(1);
      OP_POSTINC: x_new = XW'(acc_q) + XW'(1);
      OP_MUL:     x_new = XW'(prod);
      OP_DIV:     x_new = '0;
      OP_NEG:     x_new = -XW'(acc_q);
      default:    x_new = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    acc_d        = acc_q;
    op_d         = op_q;
    status_d     = status_q;
    x_d          = x_q;
    qneg_d       = qneg_q;
    tneg_d       = tneg_q;
    wrap_d       = wrap_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    div_ctrl     = '0;
    div_dividend = {acc_abs, W'(0)};
    div_divisor  = {1'b0, b_abs};
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = in_op;
          status_d = ST_OK;
          priority if (range_empty) begin
            status_d = ST_EMPTY;
            state_d  = S_WB;
          end else if (in_op == OP_DIV && in_b == '0) begin
            status_d = ST_DIVZ;
            state_d  = S_WB;
          end else if (in_op == OP_DIV) begin
            div_ctrl.start = 1'b1;
            qneg_d         = acc_q[W-1] ^ in_b[W-1];
            state_d        = S_DIV;
          end else begin
            x_d     = x_new;
            state_d = S_SUBL;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (!div_stat.rem_zero) begin
          status_d = ST_NDIV;
          state_d  = S_WB;
        end else begin
          x_d     = qneg_q ? -q_ext : q_ext;
          state_d = S_SUBL;
        end
      end
      S_SUBL: begin
        x_d     = x_q - XW'(low_q);
        state_d = S_MSET;
      end
      S_MSET: begin
        div_ctrl.start    = 1'b1;
        div_ctrl.long_run = 1'b1;
        div_dividend      = x_abs[DW-1:0];
        div_divisor       = span;
        tneg_d            = x_q[XW-1];
        state_d           = S_MOD;
      end
      S_MOD: begin
        if (div_stat.done) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        wrap_d  = wrap_sum[W-1:0];
        state_d = S_WB;
      end
      S_WB: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          if (status_q != ST_OK || op_q == OP_POSTINC) begin
            out_data_d = acc_q;
          end else begin
            out_data_d = wrap_q;
          end
          if (status_q == ST_OK && op_q != OP_NEG) begin
            acc_d = wrap_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= W'(1);
      high_q <= W'(12);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE_LOW:  low_q  <= cfg_data_i;
        REG_RANGE_HIGH: high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    status_q     <= status_d;
    x_q          <= x_d;
    qneg_q       <= qneg_d;
    tneg_q       <= tneg_d;
    wrap_q       <= wrap_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDW'(out_data_q);
  assign m_axis_tuser  = out_status_q;

endmodule

FILE: hw/rtl/rwalu_checker.sv
`timescale 1ns / 1ps
// port level checks of the range wrapped integer alu, bound to the top level
module rwalu_checker #(
  parameter  int unsigned VALUE_WIDTH = 16,
  localparam int unsigned TDW         = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [TDW-1:0]                   m_axis_tdata,
  input logic [rwalu_pkg::ST_W-1:0]       m_axis_tuser
);

  logic [1:0] pend_q, pend_d;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("second item taken while one is at work");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 2'd0)
    else $error("result without an item");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready)
    else $error("item taken with result and work both pending");

endmodule

bind range_wrapped_integer_alu_core rwalu_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_rwalu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
